/* sv/kabf_pkg.sv */
`default_nettype none
package kabf_pkg;

    // Multiplier operand and product widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Sum width used before saturation
    localparam int SUM_W = 40;

    // Configuration register width and index width
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_R  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] ANGLE_Q_RST = 31'd268435;
    localparam logic [CFG_W-1:0] BIAS_Q_RST  = 31'd805306;
    localparam logic [CFG_W-1:0] MEAS_R_RST  = 31'd8053064;

    // Divider widths: numerator magnitude, divisor magnitude, signed divisor
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 33;
    localparam int SDEN_W = 34;

    // Clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(SUM_W-32){1'b0}}, 32'h7fffffff})) begin
            r = 32'sh7fffffff;
        end else if (x < $signed({{(SUM_W-32){1'b1}}, 32'h80000000})) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/kalman_angle_bias_filter_core.sv */
// Sequence from input request to m_tvalid: ten steps through one shared
// registered multiplier and two gain divisions through one shared radix-2
// divider; a zero innovation variance or an overflowing gain ends a division in its load step.
// Requests do not overlap; s_tready is high only when idle, and a held
// result with m_tready low stalls the output step.
// Reset (aresetn low, synchronous): state cleared, noise defaults, no result pending.
`default_nettype none
module kalman_angle_bias_filter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [24:0] measured_angle, [49:25] gyro_rate, [65:50] time_step, [71:66] zero
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] filtered_angle, [63:32] rate_bias
    output logic [63:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [kabf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kabf_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int SW = kabf_pkg::SUM_W;
    localparam int AW = kabf_pkg::MUL_A_W;
    localparam int BW = kabf_pkg::MUL_B_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_A    = 5'd1;
    localparam logic [4:0] S_B    = 5'd2;
    localparam logic [4:0] S_C    = 5'd3;
    localparam logic [4:0] S_D    = 5'd4;
    localparam logic [4:0] S_E    = 5'd5;
    localparam logic [4:0] S_F    = 5'd6;
    localparam logic [4:0] S_G    = 5'd7;
    localparam logic [4:0] S_H    = 5'd8;
    localparam logic [4:0] S_I    = 5'd9;
    localparam logic [4:0] S_J    = 5'd10;
    localparam logic [4:0] S_K    = 5'd11;
    localparam logic [4:0] S_L    = 5'd12;
    localparam logic [4:0] S_M    = 5'd13;
    localparam logic [4:0] S_N    = 5'd14;
    localparam logic [4:0] S_O    = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0] st_reg, st_next;

    logic [kabf_pkg::CFG_W-1:0] qa_reg, qb_reg, rr_reg;

    logic signed [31:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [31:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next, p11_reg, p11_next;

    logic signed [24:0] meas_reg, meas_next, rin_reg, rin_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [32:0] d11_reg, d11_next;
    logic signed [AW-1:0] inner_reg, inner_next;
    logic signed [kabf_pkg::SDEN_W-1:0] s_reg, s_next;
    logic signed [31:0] y_reg, y_next, k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0] n00_reg, n00_next, n01_reg, n01_next;

    logic        mv_reg, mv_next;
    logic [63:0] mdata_reg, mdata_next;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [kabf_pkg::PROD_W-1:0] prod;
    logic signed [SW-1:0] sh16, sh28;

    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quot;

    logic accept;
    logic signed [BW-1:0] dt_b;

    kabf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    kabf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (s_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_tready = (st_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign dt_b     = $signed({16'd0, dt_reg});

    // Scaled-back products
    assign sh16 = prod[SW+15:16];
    assign sh28 = {prod[kabf_pkg::PROD_W-1], prod[kabf_pkg::PROD_W-1:28]};

    always_comb begin
        st_next    = st_reg;
        ang_next   = ang_reg;
        bias_next  = bias_reg;
        p00_next   = p00_reg;
        p01_next   = p01_reg;
        p10_next   = p10_reg;
        p11_next   = p11_reg;
        meas_next  = meas_reg;
        rin_next   = rin_reg;
        dt_next    = dt_reg;
        d11_next   = d11_reg;
        inner_next = inner_reg;
        s_next     = s_reg;
        y_next     = y_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        n00_next   = n00_reg;
        n01_next   = n01_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = p00_reg;

        case (st_reg)
            S_IDLE: begin
                // Take the request
                if (accept) begin
                    meas_next = s_tdata[24:0];
                    rin_next  = s_tdata[49:25];
                    dt_next   = s_tdata[65:50];
                    st_next   = S_A;
                end
            end
            S_A: begin
                // dt * (rate - bias)
                mul_a   = AW'(SW'(rin_reg) - SW'(bias_reg));
                mul_b   = dt_b;
                st_next = S_B;
            end
            S_B: begin
                // Predict angle; dt * P11
                ang_next = kabf_pkg::sat32(SW'(ang_reg) + sh16);
                mul_a    = AW'(p11_reg);
                mul_b    = dt_b;
                st_next  = S_C;
            end
            S_C: begin
                d11_next = sh16[32:0];
                mul_a    = AW'({1'b0, qb_reg});
                mul_b    = dt_b;
                st_next  = S_D;
            end
            S_D: begin
                // Propagate P11, P01, P10 and form the P00 inner term
                p11_next   = kabf_pkg::sat32(SW'(p11_reg) + sh16);
                inner_next = AW'(SW'(d11_reg) - SW'(p01_reg) - SW'(p10_reg)
                                 + SW'({1'b0, qa_reg}));
                p01_next   = kabf_pkg::sat32(SW'(p01_reg) - SW'(d11_reg));
                p10_next   = kabf_pkg::sat32(SW'(p10_reg) - SW'(d11_reg));
                st_next    = S_E;
            end
            S_E: begin
                mul_a   = inner_reg;
                mul_b   = dt_b;
                st_next = S_F;
            end
            S_F: begin
                p00_next = kabf_pkg::sat32(SW'(p00_reg) + sh16);
                st_next  = S_G;
            end
            S_G: begin
                // Innovation variance and residual
                s_next  = kabf_pkg::SDEN_W'(SW'(p00_reg) + SW'({1'b0, rr_reg}));
                y_next  = kabf_pkg::sat32(SW'(meas_reg) - SW'(ang_reg));
                st_next = S_H;
            end
            S_H: begin
                // Gain K0 = P00 / S
                div_num = p00_reg;
                if (!div_done) begin
                    div_start = 1'b1;
                end
                if (div_done) begin
                    k0_next = div_quot;
                    st_next = S_I;
                end
            end
            S_I: begin
                // Gain K1 = P10 / S
                div_num = p10_reg;
                if (!div_done) begin
                    div_start = 1'b1;
                end
                if (div_done) begin
                    k1_next = div_quot;
                    mul_a   = AW'(k0_reg);
                    mul_b   = y_reg;
                    st_next = S_J;
                end
            end
            S_J: begin
                ang_next = kabf_pkg::sat32(SW'(ang_reg) + sh28);
                mul_a    = AW'(k1_reg);
                mul_b    = y_reg;
                st_next  = S_K;
            end
            S_K: begin
                bias_next = kabf_pkg::sat32(SW'(bias_reg) + sh28);
                mul_a     = AW'(k0_reg);
                mul_b     = p00_reg;
                st_next   = S_L;
            end
            S_L: begin
                n00_next = kabf_pkg::sat32(SW'(p00_reg) - sh28);
                mul_a    = AW'(k0_reg);
                mul_b    = p01_reg;
                st_next  = S_M;
            end
            S_M: begin
                n01_next = kabf_pkg::sat32(SW'(p01_reg) - sh28);
                mul_a    = AW'(k1_reg);
                mul_b    = p00_reg;
                st_next  = S_N;
            end
            S_N: begin
                p00_next = n00_reg;
                p10_next = kabf_pkg::sat32(SW'(p10_reg) - sh28);
                mul_a    = AW'(k1_reg);
                mul_b    = p01_reg;
                st_next  = S_O;
            end
            S_O: begin
                p01_next = n01_reg;
                p11_next = kabf_pkg::sat32(SW'(p11_reg) - sh28);
                st_next  = S_OUT;
            end
            S_OUT: begin
                // Hand the result to the output register once it is free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {bias_reg, ang_reg};
                    st_next    = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            mv_reg    <= 1'b0;
            qa_reg    <= kabf_pkg::ANGLE_Q_RST;
            qb_reg    <= kabf_pkg::BIAS_Q_RST;
            rr_reg    <= kabf_pkg::MEAS_R_RST;
            ang_reg   <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end else begin
            st_reg    <= st_next;
            mv_reg    <= mv_next;
            ang_reg   <= ang_next;
            bias_reg  <= bias_next;
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            // Store configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    kabf_pkg::CFG_ANGLE_Q: qa_reg <= cfg_wdata;
                    kabf_pkg::CFG_BIAS_Q:  qb_reg <= cfg_wdata;
                    kabf_pkg::CFG_MEAS_R:  rr_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        meas_reg  <= meas_next;
        rin_reg   <= rin_next;
        dt_reg    <= dt_next;
        d11_reg   <= d11_next;
        inner_reg <= inner_next;
        s_reg     <= s_next;
        y_reg     <= y_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        n00_reg   <= n00_next;
        n01_reg   <= n01_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (st_reg == S_A))
        else $error("request did not start the sequence");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == S_H || st_reg == S_I))
        else $error("divider finished outside a gain step");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(st_reg) == S_OUT))
        else $error("result appeared outside the output step");

    a_div_go_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (st_reg == S_H || st_reg == S_I))
        else $error("divider started outside a gain step");
`endif

endmodule
`default_nettype wire

/* sv/kabf_mul.sv */
`default_nettype none
module kabf_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [kabf_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic signed [kabf_pkg::MUL_B_W-1:0]  op_b,
    output logic signed      [kabf_pkg::PROD_W-1:0]   prod
);

    logic signed [kabf_pkg::PROD_W-1:0] prod_reg;
    logic signed [kabf_pkg::PROD_W-1:0] prod_next;

    // Exact signed product, registered
    always_comb begin
        prod_next = kabf_pkg::PROD_W'(op_a) * kabf_pkg::PROD_W'(op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* sv/kabf_div.sv */
`default_nettype none
module kabf_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [31:0]                    num,
    input  wire logic signed [kabf_pkg::SDEN_W-1:0]    den,
    output logic                                       done,
    output logic signed [31:0]                         quot
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BUSY = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;
    localparam int DEN_W = kabf_pkg::DEN_W;

    logic [1:0]        ph_reg, ph_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  lo_reg, lo_next;
    logic [DEN_W-1:0]  q_reg, q_next;
    logic [DEN_W-1:0]  d_reg, d_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic signed [31:0] quot_reg, quot_next;

    logic [kabf_pkg::NUM_W-1:0] mag_n;
    logic [DEN_W-1:0]           mag_d;
    logic [DEN_W-1:0]           hi;
    logic [DEN_W:0]             trial;
    logic [DEN_W:0]             diff;
    logic                       neg_s;

    always_comb begin
        mag_n = num[31] ? (32'd0 - num) : num;
        mag_d = den[kabf_pkg::SDEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        hi    = {6'd0, mag_n[31:5]};
        neg_s = num[31] ^ den[kabf_pkg::SDEN_W-1];
        trial = {rem_reg, lo_reg[DEN_W-1]};
        diff  = trial - {1'b0, d_reg};

        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quot_next = quot_reg;

        case (ph_reg)
            PH_IDLE: begin
                // Load operands; settle zero divisor and overflow at once
                if (start) begin
                    neg_next = neg_s;
                    d_next   = mag_d;
                    rem_next = hi;
                    lo_next  = {mag_n[4:0], 28'd0};
                    q_next   = '0;
                    cnt_next = 6'(DEN_W);
                    if (mag_d == '0) begin
                        quot_next = '0;
                        done_next = 1'b1;
                    end else if (hi >= mag_d) begin
                        quot_next = neg_s ? 32'sh80000000 : 32'sh7fffffff;
                        done_next = 1'b1;
                    end else begin
                        ph_next = PH_BUSY;
                    end
                end
            end
            PH_BUSY: begin
                // One restoring step per cycle
                if (!diff[DEN_W]) begin
                    rem_next = diff[DEN_W-1:0];
                    q_next   = {q_reg[DEN_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DEN_W-1:0];
                    q_next   = {q_reg[DEN_W-2:0], 1'b0};
                end
                lo_next  = {lo_reg[DEN_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    ph_next = PH_FIN;
                end
            end
            PH_FIN: begin
                // Apply sign and clamp
                if (neg_reg) begin
                    if (q_reg[32] || (q_reg[31] && (|q_reg[30:0]))) begin
                        quot_next = 32'sh80000000;
                    end else begin
                        quot_next = 32'd0 - q_reg[31:0];
                    end
                end else begin
                    if (q_reg[32] || q_reg[31]) begin
                        quot_next = 32'sh7fffffff;
                    end else begin
                        quot_next = q_reg[31:0];
                    end
                end
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default: begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [24:0] measured_angle, [49:25] gyro_rate, [65:50] time_step, [71:66] zero
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [31:0] filtered_angle, [63:32] rate_bias
    logic [63:0] m_tdata;
    logic        cfg_wr_en;
    logic [kabf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [kabf_pkg::CFG_W-1:0]     cfg_wdata;

    kalman_angle_bias_filter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Angle in the low half, bias in the high half, as on m_tdata
    typedef struct packed {
        logic signed [31:0] bias;
        logic signed [31:0] angle;
    } estimate_t;

    // Filter state mirrored by the predictor
    logic [30:0]        noise_angle_q, noise_bias_q, noise_meas_r;
    logic signed [31:0] est_angle, est_bias;
    logic signed [31:0] cov [4];

    estimate_t expected_estimates [$];
    int        error_count = 0;
    int        checked_count = 0;
    int        sent_count;
    int        idle_cycles = 0;
    bit        burst_mode;
    int        stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint shr_floor(longint x, int n);
        return x >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] kalman_gain(longint num, longint den);
        longint q;
        if (den == 0) return 32'sd0;
        q = (num * (64'sd1 <<< 28)) / den;
        return clamp32(q);
    endfunction

    task automatic reset_model();
        noise_angle_q = kabf_pkg::ANGLE_Q_RST;
        noise_bias_q  = kabf_pkg::BIAS_Q_RST;
        noise_meas_r  = kabf_pkg::MEAS_R_RST;
        est_angle = 0;
        est_bias  = 0;
        for (int i = 0; i < 4; i++) cov[i] = 0;
    endtask

    // Advance the filter by one sample and queue the estimate it yields
    task automatic predict_estimate(logic [24:0] meas_bits, logic [24:0] rate_bits,
                                    logic [15:0] dt_bits);
        longint meas, rate, dt, p00, p01, p10, p11, d11, inner, s, y;
        longint k0, k1;
        estimate_t e;
        meas = longint'($signed(meas_bits));
        rate = longint'($signed(rate_bits));
        dt   = longint'(dt_bits);
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        rate = rate - est_bias;
        est_angle = clamp32(est_angle + shr_floor(dt * rate, 16));
        d11 = shr_floor(dt * p11, 16);
        inner = d11 - p01 - p10 + longint'(noise_angle_q);
        p00 = clamp32(p00 + shr_floor(dt * inner, 16));
        p01 = clamp32(p01 - d11);
        p10 = clamp32(p10 - d11);
        p11 = clamp32(p11 + shr_floor(longint'(noise_bias_q) * dt, 16));
        s  = p00 + longint'(noise_meas_r);
        k0 = kalman_gain(p00, s);
        k1 = kalman_gain(p10, s);
        y  = clamp32(meas - est_angle);
        est_angle = clamp32(est_angle + shr_floor(k0 * y, 28));
        est_bias  = clamp32(est_bias + shr_floor(k1 * y, 28));
        cov[0] = clamp32(p00 - shr_floor(k0 * p00, 28));
        cov[1] = clamp32(p01 - shr_floor(k0 * p01, 28));
        cov[2] = clamp32(p10 - shr_floor(k1 * p00, 28));
        cov[3] = clamp32(p11 - shr_floor(k1 * p01, 28));
        e.angle = est_angle;
        e.bias  = est_bias;
        expected_estimates.push_back(e);
    endtask

    // Send one sample request, with a random gap when not in a burst
    task automatic send_sample(logic [24:0] meas, logic [24:0] rate, logic [15:0] dt);
        int gap;
        gap = 0;
        if (!burst_mode || $urandom_range(0, 15) == 0) begin
            burst_mode = ($urandom_range(0, 2) != 0);
            gap = $urandom_range(0, burst_mode ? 0 : 120);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, dt, rate, meas};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_estimate(meas, rate, dt);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_noise(logic [kabf_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            kabf_pkg::CFG_ANGLE_Q: noise_angle_q = val;
            kabf_pkg::CFG_BIAS_Q:  noise_bias_q  = val;
            kabf_pkg::CFG_MEAS_R:  noise_meas_r  = val;
            default: ;
        endcase
    endtask

    function automatic logic [24:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 25'($urandom());
            1: return 25'h0ffffff;
            2: return 25'h1000000;
            default: return 25'($signed($urandom_range(0, 23592960)) - 11796480);
        endcase
    endfunction

    function automatic logic [24:0] rand_rate();
        if ($urandom_range(0, 3) == 0) return 25'($urandom());
        return 25'($signed($urandom_range(0, 1310720)) - 655360);
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 7))
            0: return 16'($urandom());
            1: return 16'd0;
            default: return 16'($urandom_range(30, 1400));
        endcase
    endfunction

    // Drive field extremes, zero time steps, zero measurement noise and saturating noise
    task automatic test_directed();
        send_sample(25'd0, 25'd0, 16'd0);
        send_sample(25'h0b40000, 25'd0, 16'd655);
        send_sample(25'h14c0000, 25'h0ffffff, 16'hffff);
        send_sample(25'h0ffffff, 25'h1000000, 16'hffff);
        send_sample(25'h1000000, 25'h1ffffff, 16'd1);
        send_sample(25'h1ffffff, 25'h0ffffff, 16'hffff);
        send_sample(25'h0ffffff, 25'h0ffffff, 16'hffff);
        send_sample(25'h1000000, 25'h1000000, 16'hffff);
        wait_drained();
        // Zero innovation variance: no noise at all drives P00 to zero
        write_noise(kabf_pkg::CFG_ANGLE_Q, 31'd0);
        write_noise(kabf_pkg::CFG_BIAS_Q, 31'd0);
        write_noise(kabf_pkg::CFG_MEAS_R, 31'd0);
        for (int i = 0; i < 6; i++)
            send_sample(rand_angle(), rand_rate(), (i < 3) ? 16'd0 : 16'd100);
        wait_drained();
        // Huge noise drives the variances and gains into saturation
        write_noise(kabf_pkg::CFG_ANGLE_Q, 31'h7fffffff);
        write_noise(kabf_pkg::CFG_BIAS_Q, 31'h7fffffff);
        write_noise(kabf_pkg::CFG_MEAS_R, 31'd1);
        for (int i = 0; i < 10; i++)
            send_sample(rand_angle(), rand_rate(), 16'hffff - 16'(i));
        wait_drained();
    endtask

    // Random samples under a sequence of noise settings
    task automatic test_random();
        logic [30:0] settings [6][3];
        settings[0] = '{kabf_pkg::ANGLE_Q_RST, kabf_pkg::BIAS_Q_RST, kabf_pkg::MEAS_R_RST};
        settings[1] = '{31'd0, 31'd0, 31'h7fffffff};
        settings[2] = '{31'h7fffffff, 31'd1, 31'd0};
        settings[3] = '{31'd1000, 31'd300000, 31'd50000};
        settings[4] = '{31'd0, 31'h7fffffff, 31'd8053064};
        settings[5] = '{31'd268435, 31'd805306, 31'd0};
        for (int ph = 0; ph < 6; ph++) begin
            write_noise(kabf_pkg::CFG_ANGLE_Q, settings[ph][0]);
            write_noise(kabf_pkg::CFG_BIAS_Q, settings[ph][1]);
            write_noise(kabf_pkg::CFG_MEAS_R, settings[ph][2]);
            stall_pct = (ph % 3 == 0) ? 0 : 20 * (ph % 3);
            for (int i = 0; i < 200; i++) begin
                send_sample(rand_angle(), rand_rate(), rand_dt());
            end
            wait_drained();
        end
        // Fully random register values
        for (int i = 0; i < 3; i++) begin
            write_noise(kabf_pkg::CFG_ANGLE_Q, 31'($urandom()));
            write_noise(kabf_pkg::CFG_BIAS_Q, 31'($urandom()));
            write_noise(kabf_pkg::CFG_MEAS_R, 31'($urandom()));
            for (int j = 0; j < 40; j++)
                send_sample(25'($urandom()), 25'($urandom()), 16'($urandom()));
            wait_drained();
        end
    endtask

    // Receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each result with the oldest pending estimate
    always @(posedge aclk) begin
        estimate_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_estimates.size() == 0) begin
                error_count++;
                if (error_count <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_estimates.pop_front();
                checked_count++;
                if (got.angle !== want.angle || got.bias !== want.bias) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: angle exp %h got %h, bias exp %h got %h",
                                 want.angle, got.angle, want.bias, got.bias);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sent_count = 0;
        burst_mode = 1'b0;
        stall_pct = 30;
        reset_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random();
        $display("covered %0d samples and %0d checked estimates", sent_count, checked_count);
        $display("across directed extremes and nine noise settings");
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
